FILE: rtl/circle_segment_collision_unit_assert.svh
// Assertion macros shared by the circle and segment collision checks.
`ifndef CIRCLE_SEGMENT_COLLISION_UNIT_ASSERT_SVH
`define CIRCLE_SEGMENT_COLLISION_UNIT_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define CSC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("circle segment collision check failed");

// Consequence must hold in the cycle after the antecedent.
`define CSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("circle segment collision check failed");

`endif

FILE: rtl/csc_pkg.sv
// Shared types and constants for the circle and segment collision unit.
`default_nettype none

package csc_pkg;

  // Default coordinate width and the fixed radius width.
  localparam int COORD_BITS_DEFAULT  = 12;
  localparam int RADIUS_BITS         = 11;
  localparam int RSQ_BITS            = 2 * RADIUS_BITS;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // Kind of contact reported with each result item.
  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_ENDPOINT = 2'd1,
    KIND_INTERIOR = 2'd2
  } kind_t;

  // Classification made by the front for each item.
  typedef struct packed {
    logic endp;  // an endpoint lies within the circle
    logic cand;  // non-empty segment with the centre projecting inside it
  } class_t;

endpackage

`default_nettype wire

FILE: rtl/circle_segment_collision_unit.sv
// Top level of the circle and line segment collision unit.
//
//   channel  direction  handshake            payload
//   in       into unit  in_valid / in_stall  seg_ax seg_ay seg_bx seg_by center_x center_y radius
//   out      from unit  out_valid / out_stall  hit hit_kind
//
// One item is accepted per clock while in_stall is low; each gives exactly one result item.
// With no stalls a result passes, from the edge that accepts its item, through the first
// front stage, two more front stages, the queue, the squaring stage and the output register.
// A stall on the output fills the queue first; the input stalls only once the queue is full.
// Reset is synchronous and empties the pipeline and the queue.
`default_nettype none

module circle_segment_collision_unit import csc_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [COORD_BITS-1:0]  seg_ax,
  input  wire logic signed [COORD_BITS-1:0]  seg_ay,
  input  wire logic signed [COORD_BITS-1:0]  seg_bx,
  input  wire logic signed [COORD_BITS-1:0]  seg_by,
  input  wire logic signed [COORD_BITS-1:0]  center_x,
  input  wire logic signed [COORD_BITS-1:0]  center_y,
  input  wire logic        [RADIUS_BITS-1:0] radius,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               hit,
  output logic [1:0]                         hit_kind
);

  localparam int TW = 2 * COORD_BITS + 3;
  localparam int SW = 2 * COORD_BITS + 2;
  localparam int QW = $bits(class_t) + TW + SW + RSQ_BITS;

  logic                 f_push;
  class_t               f_cls;
  logic signed [TW-1:0] f_cross;
  logic [SW-1:0]        f_len2;
  logic [RSQ_BITS-1:0]  f_rsq;

  logic                 q_full;
  logic                 q_pop;
  logic                 q_nonempty;
  logic [QW-1:0]        q_wdata;
  logic [QW-1:0]        q_rdata;
  class_t               q_cls;
  logic signed [TW-1:0] q_cross;
  logic [SW-1:0]        q_len2;
  logic [RSQ_BITS-1:0]  q_rsq;

  csc_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .seg_ax     (seg_ax),
    .seg_ay     (seg_ay),
    .seg_bx     (seg_bx),
    .seg_by     (seg_by),
    .center_x   (center_x),
    .center_y   (center_y),
    .radius     (radius),
    .q_full     (q_full),
    .push       (f_push),
    .cls        (f_cls),
    .cross_prod (f_cross),
    .len2       (f_len2),
    .rsq        (f_rsq)
  );

  // Classified items are packed into one queue word.
  assign q_wdata = {f_cls, f_cross, f_len2, f_rsq};
  assign {q_cls, q_cross, q_len2, q_rsq} = q_rdata;

  csc_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (f_push),
    .wdata    (q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .rdata    (q_rdata),
    .nonempty (q_nonempty)
  );

  csc_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_cls      (q_cls),
    .q_cross    (q_cross),
    .q_len2     (q_len2),
    .q_rsq      (q_rsq),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hit        (hit),
    .hit_kind   (hit_kind)
  );

endmodule

`default_nettype wire

FILE: rtl/csc_front.sv
// Front part: accepts items, forms the products and sums, and classifies each item.
`default_nettype none

module csc_front import csc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [COORD_BITS-1:0]       seg_ax,
  input  wire logic signed [COORD_BITS-1:0]       seg_ay,
  input  wire logic signed [COORD_BITS-1:0]       seg_bx,
  input  wire logic signed [COORD_BITS-1:0]       seg_by,
  input  wire logic signed [COORD_BITS-1:0]       center_x,
  input  wire logic signed [COORD_BITS-1:0]       center_y,
  input  wire logic        [RADIUS_BITS-1:0]      radius,
  input  wire logic                               q_full,
  output logic                                    push,
  output class_t                                  cls,
  output logic signed [2*COORD_BITS+2:0]          cross_prod,
  output logic        [2*COORD_BITS+1:0]          len2,
  output logic        [RSQ_BITS-1:0]              rsq
);

  localparam int DW  = COORD_BITS + 1;
  localparam int PRW = 2 * COORD_BITS + 2;
  localparam int SW  = PRW;
  localparam int TW  = 2 * COORD_BITS + 3;
  localparam int EW  = (SW > RSQ_BITS) ? SW : RSQ_BITS;

  logic adv;

  logic s1_valid;
  logic s2_valid;
  logic s3_valid;

  // Differences taken in the first stage.
  logic signed [DW-1:0] ux;
  logic signed [DW-1:0] uy;
  logic signed [DW-1:0] vx;
  logic signed [DW-1:0] vy;
  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic signed [DW-1:0] wx;
  logic signed [DW-1:0] wy;
  logic [RADIUS_BITS-1:0] s1_rad;

  // Products taken in the second stage.
  logic signed [PRW-1:0] uxx;
  logic signed [PRW-1:0] uyy;
  logic signed [PRW-1:0] vxx;
  logic signed [PRW-1:0] vyy;
  logic signed [PRW-1:0] dxx;
  logic signed [PRW-1:0] dyy;
  logic signed [PRW-1:0] tpx;
  logic signed [PRW-1:0] tpy;
  logic signed [PRW-1:0] cpa;
  logic signed [PRW-1:0] cpb;
  logic [RSQ_BITS-1:0]   s2_rsq;

  // Sums and comparisons of the third stage.
  logic [SW-1:0]        du;
  logic [SW-1:0]        dv;
  logic [SW-1:0]        len2_sum;
  logic signed [TW-1:0] tproj;
  logic signed [TW-1:0] cross_sum;
  class_t               cls_next;

  // The whole front moves unless a finished item cannot enter the queue.
  assign adv      = !s3_valid || !q_full;
  assign in_stall = !adv;
  assign push     = s3_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // Stage one: offsets of the endpoints from the centre, and the segment vector.
  always_ff @(posedge clk) begin
    if (adv) begin
      ux     <= DW'(seg_ax) - DW'(center_x);
      uy     <= DW'(seg_ay) - DW'(center_y);
      vx     <= DW'(seg_bx) - DW'(center_x);
      vy     <= DW'(seg_by) - DW'(center_y);
      dx     <= DW'(seg_bx) - DW'(seg_ax);
      dy     <= DW'(seg_by) - DW'(seg_ay);
      wx     <= DW'(center_x) - DW'(seg_ax);
      wy     <= DW'(center_y) - DW'(seg_ay);
      s1_rad <= radius;
    end
  end

  // Stage two: squares, dot product terms and cross product terms.
  always_ff @(posedge clk) begin
    if (adv) begin
      uxx    <= PRW'(ux) * PRW'(ux);
      uyy    <= PRW'(uy) * PRW'(uy);
      vxx    <= PRW'(vx) * PRW'(vx);
      vyy    <= PRW'(vy) * PRW'(vy);
      dxx    <= PRW'(dx) * PRW'(dx);
      dyy    <= PRW'(dy) * PRW'(dy);
      tpx    <= PRW'(wx) * PRW'(dx);
      tpy    <= PRW'(wy) * PRW'(dy);
      cpa    <= PRW'(wx) * PRW'(dy);
      cpb    <= PRW'(wy) * PRW'(dx);
      s2_rsq <= RSQ_BITS'(s1_rad) * RSQ_BITS'(s1_rad);
    end
  end

  // Stage three sums; the projection must lie between zero and the squared length.
  always_comb begin
    du        = $unsigned(uxx) + $unsigned(uyy);
    dv        = $unsigned(vxx) + $unsigned(vyy);
    len2_sum  = $unsigned(dxx) + $unsigned(dyy);
    tproj     = TW'(tpx) + TW'(tpy);
    cross_sum = TW'(cpa) - TW'(cpb);
    cls_next.endp = (EW'(du) <= EW'(s2_rsq)) || (EW'(dv) <= EW'(s2_rsq));
    cls_next.cand = (len2_sum != '0) && !tproj[TW-1] && (tproj[SW-1:0] <= len2_sum);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cls        <= cls_next;
      cross_prod <= cross_sum;
      len2       <= len2_sum;
      rsq        <= s2_rsq;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/csc_queue.sv
// Short first-in first-out queue between the front and the back.
`default_nettype none

module csc_queue import csc_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  nonempty
);

  localparam int PTRW = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PTRW-1:0]  wr_ptr;
  logic [PTRW-1:0]  rd_ptr;
  logic [CNTW-1:0]  count;

  assign full     = (count == CNTW'(DEPTH));
  assign nonempty = (count != '0);
  assign rdata    = store[rd_ptr];

  // Pointers wrap at the depth, which need not be a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTRW'(DEPTH - 1)) ? '0 : wr_ptr + PTRW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTRW'(DEPTH - 1)) ? '0 : rd_ptr + PTRW'(1);
      end
      if (push && !pop) begin
        count <= count + CNTW'(1);
      end else if (pop && !push) begin
        count <= count - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/csc_back.sv
// Back part: squares the cross product, makes the distance test and holds the result.
`default_nettype none

module csc_back import csc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               q_nonempty,
  input  wire class_t                             q_cls,
  input  wire logic signed [2*COORD_BITS+2:0]     q_cross,
  input  wire logic        [2*COORD_BITS+1:0]     q_len2,
  input  wire logic        [RSQ_BITS-1:0]         q_rsq,
  output logic                                    pop,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    hit,
  output logic [1:0]                              hit_kind
);

  localparam int TW   = 2 * COORD_BITS + 3;
  localparam int SW   = 2 * COORD_BITS + 2;
  localparam int SQW  = 2 * TW;
  localparam int RLW  = RSQ_BITS + SW;
  localparam int CMPW = (SQW > RLW) ? SQW : RLW;

  logic adv;

  logic signed [SQW-1:0] csq;
  logic [RLW-1:0]        rl;

  logic            b1_valid;
  class_t          b1_cls;
  logic [CMPW-1:0] b1_csq;
  logic [CMPW-1:0] b1_rl;

  kind_t kind_next;
  kind_t out_kind;

  // The back moves when the output register is empty or being taken.
  assign adv = !out_valid || !out_stall;
  assign pop = adv && q_nonempty;

  // Squared cross product against squared radius times squared length.
  assign csq = SQW'(q_cross) * SQW'(q_cross);
  assign rl  = RLW'(q_rsq) * RLW'(q_len2);

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      b1_valid  <= q_nonempty;
      out_valid <= b1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_cls <= q_cls;
      b1_csq <= CMPW'($unsigned(csq));
      b1_rl  <= CMPW'(rl);
    end
  end

  // An endpoint inside the circle wins over an interior touch.
  always_comb begin
    if (b1_cls.endp) begin
      kind_next = KIND_ENDPOINT;
    end else if (b1_cls.cand && (b1_csq <= b1_rl)) begin
      kind_next = KIND_INTERIOR;
    end else begin
      kind_next = KIND_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_kind <= kind_next;
    end
  end

  assign hit      = (out_kind != KIND_NONE);
  assign hit_kind = out_kind;

endmodule

`default_nettype wire

FILE: rtl/csc_checker.sv
// Port-level checks for the collision unit, and the bind that attaches them.
`default_nettype none

`include "circle_segment_collision_unit_assert.svh"

module csc_checker import csc_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       hit,
  input wire logic [1:0] hit_kind
);

  // A result held by the receiver keeps its item.
  `CSC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(hit) && $stable(hit_kind))

  // The hit flag agrees with the kind of contact.
  `CSC_ASSERT_NOW(a_hit_kind, out_valid, hit == (hit_kind != KIND_NONE))

  // No result is shown straight after reset.
  `CSC_ASSERT_NOW(a_reset_idle, $fell(rst), !out_valid)

  // Once the output has moved, the queue has room, so the input is not held.
  `CSC_ASSERT_NOW(a_no_back_pressure, !$past(out_stall), !in_stall)

endmodule

bind circle_segment_collision_unit csc_checker u_csc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .hit       (hit),
  .hit_kind  (hit_kind)
);

`default_nettype wire
